[rtl/imq_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed min priority queue package
// Shared types, operation and status codes, and the command and status
// structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package imq_pkg;

    localparam int VID_W     = 8;
    localparam int IN_KEY_W  = 32;
    localparam int CNT_OUT_W = 8;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_EXTRACT  = 2'd1;
    localparam logic [1:0] OP_DECREASE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [1:0] ST_INVALID   = 2'd3;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [VID_W-1:0]    vertex_id;
        logic [IN_KEY_W-1:0] key_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]           status;
        logic [VID_W-1:0]     min_vertex;
        logic [IN_KEY_W-1:0]  min_key;
        logic [CNT_OUT_W-1:0] entry_count;
        logic                 heap_empty;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_EX_ROOT, S_EX_LAST, S_DK_POS, S_DK_SLOT,
        S_UP_CHECK, S_UP_PAR, S_DN_READ, S_DN_LEFT, S_DN_RIGHT, S_DN_CMP,
        S_SW_A, S_SW_B, S_SW_C, S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        HRA_ONE, HRA_COUNT, HRA_LEFT, HRA_RIGHT, HRA_PARENT, HRA_IDX
    } t_hra;

    typedef enum logic [1:0] {
        HWD_CUR, HWD_CHILD, HWD_RD
    } t_hwd;

    typedef enum logic [1:0] {
        PA_VID, PA_RDV, PA_CUR, PA_CHILD
    } t_pa;

    typedef enum logic [2:0] {
        PWD_INS, PWD_ZERO, PWD_ONE, PWD_RD, PWD_SAVED
    } t_pwd;

    typedef struct packed {
        logic       load;
        logic       fail_en;
        logic [1:0] fail_code;
        logic       ins_init;
        logic       cnt_dec;
        logic       heap_re;
        t_hra       heap_ra;
        logic       heap_we;
        t_hwd       heap_wd;
        logic       pos_re;
        t_pa        pos_ra;
        logic       pos_we;
        t_pa        pos_wa;
        t_pwd       pos_wd;
        logic       root_take;
        logic       cur_from_rd;
        logic       cur_dk;
        logic       dk_idx;
        logic       child_l;
        logic       child_r;
        logic       down_step;
        logic       up_step;
        logic       save_pos;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       vid_ok;
        logic       full;
        logic       empty;
        logic       cnt_one;
        logic       i_root;
        logic       l_out;
        logic       r_out;
        logic       dn_swap;
        logic       up_swap;
        logic       dk_bad;
        logic       out_free;
    } t_stat;

endpackage

[rtl/imq_ctrl.sv]
// ----------------------------------------------------------------------------
// Indexed min priority queue controller
// Sequences one request through dispatch, sift-up, sift-down and the
// position table swaps, one memory access per port per cycle.
// ----------------------------------------------------------------------------
module imq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  imq_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output imq_pkg::t_cmd  o_cmd
);

    imq_pkg::t_state r_state;
    imq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            imq_pkg::S_IDLE: begin
                if (i_in_valid) n_state = imq_pkg::S_DISPATCH;
            end
            imq_pkg::S_DISPATCH: begin
                case (i_stat.op)
                    imq_pkg::OP_INSERT: begin
                        if (!i_stat.vid_ok || i_stat.full) n_state = imq_pkg::S_FINISH;
                        else n_state = imq_pkg::S_UP_CHECK;
                    end
                    imq_pkg::OP_EXTRACT: begin
                        if (i_stat.empty) n_state = imq_pkg::S_FINISH;
                        else n_state = imq_pkg::S_EX_ROOT;
                    end
                    imq_pkg::OP_DECREASE: begin
                        if (!i_stat.vid_ok) n_state = imq_pkg::S_FINISH;
                        else n_state = imq_pkg::S_DK_POS;
                    end
                    default: n_state = imq_pkg::S_FINISH;
                endcase
            end
            imq_pkg::S_EX_ROOT: begin
                if (i_stat.cnt_one) n_state = imq_pkg::S_FINISH;
                else n_state = imq_pkg::S_EX_LAST;
            end
            imq_pkg::S_EX_LAST: n_state = imq_pkg::S_DN_READ;
            imq_pkg::S_DK_POS: begin
                if (i_stat.dk_bad) n_state = imq_pkg::S_FINISH;
                else n_state = imq_pkg::S_DK_SLOT;
            end
            imq_pkg::S_DK_SLOT: n_state = imq_pkg::S_UP_CHECK;
            imq_pkg::S_UP_CHECK: begin
                if (i_stat.i_root) n_state = imq_pkg::S_FINISH;
                else n_state = imq_pkg::S_UP_PAR;
            end
            imq_pkg::S_UP_PAR: begin
                if (i_stat.up_swap) n_state = imq_pkg::S_SW_A;
                else n_state = imq_pkg::S_FINISH;
            end
            imq_pkg::S_DN_READ: begin
                if (i_stat.l_out) n_state = imq_pkg::S_FINISH;
                else n_state = imq_pkg::S_DN_LEFT;
            end
            imq_pkg::S_DN_LEFT: begin
                if (i_stat.r_out) n_state = imq_pkg::S_DN_CMP;
                else n_state = imq_pkg::S_DN_RIGHT;
            end
            imq_pkg::S_DN_RIGHT: n_state = imq_pkg::S_DN_CMP;
            imq_pkg::S_DN_CMP: begin
                if (i_stat.dn_swap) n_state = imq_pkg::S_SW_A;
                else n_state = imq_pkg::S_FINISH;
            end
            imq_pkg::S_SW_A: n_state = imq_pkg::S_SW_B;
            imq_pkg::S_SW_B: n_state = imq_pkg::S_SW_C;
            imq_pkg::S_SW_C: begin
                if (i_stat.op == imq_pkg::OP_EXTRACT) n_state = imq_pkg::S_DN_READ;
                else n_state = imq_pkg::S_UP_CHECK;
            end
            imq_pkg::S_FINISH: begin
                if (i_stat.out_free) n_state = imq_pkg::S_IDLE;
            end
            default: n_state = imq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            imq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            imq_pkg::S_DISPATCH: begin
                case (i_stat.op)
                    imq_pkg::OP_INSERT: begin
                        if (!i_stat.vid_ok) begin
                            o_cmd.fail_en   = 1'b1;
                            o_cmd.fail_code = imq_pkg::ST_INVALID;
                        end else if (i_stat.full) begin
                            o_cmd.fail_en   = 1'b1;
                            o_cmd.fail_code = imq_pkg::ST_OVERFLOW;
                        end else begin
                            o_cmd.ins_init = 1'b1;
                            o_cmd.pos_we   = 1'b1;
                            o_cmd.pos_wa   = imq_pkg::PA_VID;
                            o_cmd.pos_wd   = imq_pkg::PWD_INS;
                        end
                    end
                    imq_pkg::OP_EXTRACT: begin
                        if (i_stat.empty) begin
                            o_cmd.fail_en   = 1'b1;
                            o_cmd.fail_code = imq_pkg::ST_UNDERFLOW;
                        end else begin
                            o_cmd.heap_re = 1'b1;
                            o_cmd.heap_ra = imq_pkg::HRA_ONE;
                        end
                    end
                    imq_pkg::OP_DECREASE: begin
                        if (!i_stat.vid_ok) begin
                            o_cmd.fail_en   = 1'b1;
                            o_cmd.fail_code = imq_pkg::ST_INVALID;
                        end else begin
                            o_cmd.pos_re = 1'b1;
                            o_cmd.pos_ra = imq_pkg::PA_VID;
                        end
                    end
                    default: begin
                        o_cmd.fail_en   = 1'b1;
                        o_cmd.fail_code = imq_pkg::ST_INVALID;
                    end
                endcase
            end
            imq_pkg::S_EX_ROOT: begin
                o_cmd.root_take = 1'b1;
                o_cmd.pos_we    = 1'b1;
                o_cmd.pos_wa    = imq_pkg::PA_RDV;
                o_cmd.pos_wd    = imq_pkg::PWD_ZERO;
                o_cmd.cnt_dec   = 1'b1;
                if (!i_stat.cnt_one) begin
                    o_cmd.heap_re = 1'b1;
                    o_cmd.heap_ra = imq_pkg::HRA_COUNT;
                end
            end
            imq_pkg::S_EX_LAST: begin
                o_cmd.cur_from_rd = 1'b1;
                o_cmd.pos_we      = 1'b1;
                o_cmd.pos_wa      = imq_pkg::PA_RDV;
                o_cmd.pos_wd      = imq_pkg::PWD_ONE;
            end
            imq_pkg::S_DK_POS: begin
                if (i_stat.dk_bad) begin
                    o_cmd.fail_en   = 1'b1;
                    o_cmd.fail_code = imq_pkg::ST_INVALID;
                end else begin
                    o_cmd.heap_re = 1'b1;
                    o_cmd.heap_ra = imq_pkg::HRA_IDX;
                    o_cmd.dk_idx  = 1'b1;
                end
            end
            imq_pkg::S_DK_SLOT: o_cmd.cur_dk = 1'b1;
            imq_pkg::S_UP_CHECK: begin
                if (i_stat.i_root) begin
                    o_cmd.heap_we = 1'b1;
                    o_cmd.heap_wd = imq_pkg::HWD_CUR;
                end else begin
                    o_cmd.heap_re = 1'b1;
                    o_cmd.heap_ra = imq_pkg::HRA_PARENT;
                end
            end
            imq_pkg::S_UP_PAR: begin
                o_cmd.heap_we = 1'b1;
                if (i_stat.up_swap) begin
                    o_cmd.heap_wd = imq_pkg::HWD_RD;
                    o_cmd.up_step = 1'b1;
                    o_cmd.pos_re  = 1'b1;
                    o_cmd.pos_ra  = imq_pkg::PA_CUR;
                end else begin
                    o_cmd.heap_wd = imq_pkg::HWD_CUR;
                end
            end
            imq_pkg::S_DN_READ: begin
                if (i_stat.l_out) begin
                    o_cmd.heap_we = 1'b1;
                    o_cmd.heap_wd = imq_pkg::HWD_CUR;
                end else begin
                    o_cmd.heap_re = 1'b1;
                    o_cmd.heap_ra = imq_pkg::HRA_LEFT;
                end
            end
            imq_pkg::S_DN_LEFT: begin
                o_cmd.child_l = 1'b1;
                if (!i_stat.r_out) begin
                    o_cmd.heap_re = 1'b1;
                    o_cmd.heap_ra = imq_pkg::HRA_RIGHT;
                end
            end
            imq_pkg::S_DN_RIGHT: o_cmd.child_r = 1'b1;
            imq_pkg::S_DN_CMP: begin
                o_cmd.heap_we = 1'b1;
                if (i_stat.dn_swap) begin
                    o_cmd.heap_wd   = imq_pkg::HWD_CHILD;
                    o_cmd.down_step = 1'b1;
                    o_cmd.pos_re    = 1'b1;
                    o_cmd.pos_ra    = imq_pkg::PA_CUR;
                end else begin
                    o_cmd.heap_wd = imq_pkg::HWD_CUR;
                end
            end
            imq_pkg::S_SW_A: begin
                o_cmd.save_pos = 1'b1;
                o_cmd.pos_re   = 1'b1;
                o_cmd.pos_ra   = imq_pkg::PA_CHILD;
            end
            imq_pkg::S_SW_B: begin
                o_cmd.pos_we = 1'b1;
                o_cmd.pos_wa = imq_pkg::PA_CUR;
                o_cmd.pos_wd = imq_pkg::PWD_RD;
            end
            imq_pkg::S_SW_C: begin
                o_cmd.pos_we = 1'b1;
                o_cmd.pos_wa = imq_pkg::PA_CHILD;
                o_cmd.pos_wd = imq_pkg::PWD_SAVED;
            end
            imq_pkg::S_FINISH: o_cmd.out_load = i_stat.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/imq_datapath.sv]
// ----------------------------------------------------------------------------
// Indexed min priority queue datapath
// Heap slot memory, vertex position memory with valid bits, the entry being
// sifted, the compared neighbor and the result register.
// ----------------------------------------------------------------------------
module imq_datapath #(
    parameter int CAPACITY = 255,
    parameter int KEY_BITS = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  imq_pkg::t_in_item i_in_item,
    input  logic              i_out_stall,
    input  imq_pkg::t_cmd     i_cmd,
    output imq_pkg::t_stat    o_stat,
    output logic              o_out_valid,
    output imq_pkg::t_out_item o_out_item
);

    localparam int SW  = $clog2(CAPACITY + 1);
    localparam int VW  = imq_pkg::VID_W;
    localparam int EW  = VW + KEY_BITS;
    localparam int VD  = 1 << VW;

    logic [EW-1:0] m_heap [0:CAPACITY];
    logic [SW-1:0] m_pos  [0:VD-1];
    logic [VD-1:0] r_pos_vld;

    logic [EW-1:0]       r_heap_q;
    logic [SW-1:0]       r_pos_q;
    logic                r_pos_qv;
    logic [1:0]          r_op;
    logic [VW-1:0]       r_vid;
    logic [KEY_BITS-1:0] r_key;
    logic [SW-1:0]       r_count;
    logic [SW-1:0]       r_i;
    logic [SW-1:0]       r_ci;
    logic [VW-1:0]       r_cur_vid;
    logic [KEY_BITS-1:0] r_cur_key;
    logic [VW-1:0]       r_child_vid;
    logic [KEY_BITS-1:0] r_child_key;
    logic [SW-1:0]       r_pc;
    logic [1:0]          r_status;
    logic [VW-1:0]       r_mv;
    logic [KEY_BITS-1:0] r_mk;
    logic                r_out_valid;
    imq_pkg::t_out_item  r_out;

    logic [VW-1:0]       rd_vid;
    logic [KEY_BITS-1:0] rd_key;
    logic [SW-1:0]       pos_rd;
    logic [SW:0]         left_w;
    logic [SW:0]         right_w;
    logic [SW-1:0]       heap_ra;
    logic [EW-1:0]       heap_wd;
    logic [VW-1:0]       pos_ra;
    logic [VW-1:0]       pos_wa;
    logic [SW-1:0]       pos_wd;
    logic [KEY_BITS-1:0] small_key;

    assign rd_vid    = r_heap_q[EW-1:KEY_BITS];
    assign rd_key    = r_heap_q[KEY_BITS-1:0];
    assign pos_rd    = r_pos_qv ? r_pos_q : '0;
    assign left_w    = {r_i, 1'b0};
    assign right_w   = {r_i, 1'b1};
    assign small_key = (r_child_key < r_cur_key) ? r_child_key : r_cur_key;

    always_comb begin
        case (i_cmd.heap_ra)
            imq_pkg::HRA_ONE:    heap_ra = SW'(1);
            imq_pkg::HRA_COUNT:  heap_ra = r_count;
            imq_pkg::HRA_LEFT:   heap_ra = left_w[SW-1:0];
            imq_pkg::HRA_RIGHT:  heap_ra = right_w[SW-1:0];
            imq_pkg::HRA_PARENT: heap_ra = r_i >> 1;
            imq_pkg::HRA_IDX:    heap_ra = pos_rd;
            default:             heap_ra = '0;
        endcase
        case (i_cmd.heap_wd)
            imq_pkg::HWD_CUR:   heap_wd = {r_cur_vid, r_cur_key};
            imq_pkg::HWD_CHILD: heap_wd = {r_child_vid, r_child_key};
            imq_pkg::HWD_RD:    heap_wd = r_heap_q;
            default:            heap_wd = r_heap_q;
        endcase
        case (i_cmd.pos_ra)
            imq_pkg::PA_VID:   pos_ra = r_vid;
            imq_pkg::PA_RDV:   pos_ra = rd_vid;
            imq_pkg::PA_CUR:   pos_ra = r_cur_vid;
            imq_pkg::PA_CHILD: pos_ra = r_child_vid;
            default:           pos_ra = r_vid;
        endcase
        case (i_cmd.pos_wa)
            imq_pkg::PA_VID:   pos_wa = r_vid;
            imq_pkg::PA_RDV:   pos_wa = rd_vid;
            imq_pkg::PA_CUR:   pos_wa = r_cur_vid;
            imq_pkg::PA_CHILD: pos_wa = r_child_vid;
            default:           pos_wa = r_vid;
        endcase
        case (i_cmd.pos_wd)
            imq_pkg::PWD_INS:   pos_wd = r_count + SW'(1);
            imq_pkg::PWD_ZERO:  pos_wd = '0;
            imq_pkg::PWD_ONE:   pos_wd = SW'(1);
            imq_pkg::PWD_RD:    pos_wd = pos_rd;
            imq_pkg::PWD_SAVED: pos_wd = r_pc;
            default:            pos_wd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.heap_we) m_heap[r_i] <= heap_wd;
        if (i_cmd.heap_re) r_heap_q <= m_heap[heap_ra];
        if (i_cmd.pos_we) m_pos[pos_wa] <= pos_wd;
        if (i_cmd.pos_re) begin
            r_pos_q  <= m_pos[pos_ra];
            r_pos_qv <= r_pos_vld[pos_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_vld <= '0;
        end else if (i_cmd.pos_we) begin
            r_pos_vld[pos_wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.ins_init) begin
            r_count <= r_count + SW'(1);
        end else if (i_cmd.cnt_dec) begin
            r_count <= r_count - SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_in_item.opcode;
            r_vid    <= i_in_item.vertex_id;
            r_key    <= KEY_BITS'(i_in_item.key_value);
            r_status <= imq_pkg::ST_OK;
            r_mv     <= '0;
            r_mk     <= '0;
        end
        if (i_cmd.fail_en) r_status <= i_cmd.fail_code;
        if (i_cmd.root_take) begin
            r_mv <= rd_vid;
            r_mk <= rd_key;
        end
        if (i_cmd.ins_init) begin
            r_i       <= r_count + SW'(1);
            r_cur_vid <= r_vid;
            r_cur_key <= r_key;
        end
        if (i_cmd.cur_from_rd) begin
            r_i       <= SW'(1);
            r_cur_vid <= rd_vid;
            r_cur_key <= rd_key;
        end
        if (i_cmd.dk_idx) r_i <= pos_rd;
        if (i_cmd.cur_dk) begin
            r_cur_vid <= rd_vid;
            r_cur_key <= r_key;
        end
        if (i_cmd.child_l) begin
            r_child_vid <= rd_vid;
            r_child_key <= rd_key;
            r_ci        <= left_w[SW-1:0];
        end
        if (i_cmd.child_r && (rd_key < small_key)) begin
            r_child_vid <= rd_vid;
            r_child_key <= rd_key;
            r_ci        <= right_w[SW-1:0];
        end
        if (i_cmd.down_step) r_i <= r_ci;
        if (i_cmd.up_step) begin
            r_child_vid <= rd_vid;
            r_child_key <= rd_key;
            r_i         <= r_i >> 1;
        end
        if (i_cmd.save_pos) r_pc <= pos_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.status      <= r_status;
            r_out.min_vertex  <= r_mv;
            r_out.min_key     <= imq_pkg::IN_KEY_W'(r_mk);
            r_out.entry_count <= imq_pkg::CNT_OUT_W'(r_count);
            r_out.heap_empty  <= (r_count == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_comb begin
        o_stat          = '0;
        o_stat.op       = r_op;
        o_stat.vid_ok   = (r_vid != '0) && (32'(r_vid) <= CAPACITY);
        o_stat.full     = 32'(r_count) >= CAPACITY;
        o_stat.empty    = (r_count == '0);
        o_stat.cnt_one  = (r_count == SW'(1));
        o_stat.i_root   = (r_i == SW'(1));
        o_stat.l_out    = left_w > {1'b0, r_count};
        o_stat.r_out    = right_w > {1'b0, r_count};
        o_stat.dn_swap  = r_child_key < r_cur_key;
        o_stat.up_swap  = rd_key > r_cur_key;
        o_stat.dk_bad   = (pos_rd == '0) || (pos_rd > r_count);
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= CAPACITY)
        else $error("Entry count exceeds capacity.");

    a_heap_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.heap_we |-> (r_i != '0) && (r_i <= r_count))
        else $error("Heap write outside the occupied slots.");

    a_no_dec_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cnt_dec |-> (r_count != '0))
        else $error("Count decremented on an empty heap.");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |=> r_out_valid)
        else $error("Result register not valid after load.");

endmodule

[rtl/indexed_min_priority_queue.sv]
// ----------------------------------------------------------------------------
// Indexed min priority queue
// Binary min-heap of (vertex, key) pairs with a vertex position table,
// supporting insert, extract minimum and decrease key.
// ----------------------------------------------------------------------------
// The input channel carries one request (opcode, vertex id, key) on
// i_in_valid / o_in_stall; the output channel returns exactly one result
// (status, extracted vertex and key, entry count, empty flag) on
// o_out_valid / i_out_stall. One request is worked at a time by a state
// machine that makes at most one access per cycle to each of the heap slot
// memory and the position memory. A request rejected at dispatch goes
// straight from acceptance to the result register, and a decrease of an
// absent vertex is rejected after its position lookup. An insert sifts the
// new entry up level by level, and a decrease looks up the vertex's slot and
// then sifts up; an extract takes the root and sifts the last entry down from
// it. The next request is accepted once the result is loaded, while that
// result may still wait on i_out_stall; a stalled result holds, and a
// finished request waits for the result register to free. After reset the
// heap is empty and every vertex reads as absent, with no clearing pass.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue #(
    parameter int CAPACITY = 255,
    parameter int KEY_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  imq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output imq_pkg::t_out_item o_out_item
);

    imq_pkg::t_cmd  cmd;
    imq_pkg::t_stat stat;
    logic           in_ready;

    imq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    imq_datapath #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = !in_ready;

endmodule
